FILE: design/b32e_pkg.sv
// Shared types, constants and alphabet lookup for the z-base-32 byte encoder.
package b32e_pkg;

  localparam int unsigned SymW      = 5;
  localparam int unsigned MaxSyms   = 3;
  localparam int unsigned QueueDepth = 2;

  typedef logic [SymW-1:0] sym_t;

  typedef struct packed {
    sym_t [MaxSyms-1:0] syms;
    logic [1:0]         cnt;
    logic               eom;
  } job_t;

  function automatic logic [7:0] sym_to_char(sym_t s);
    logic [7:0] c;
    case (s)
      5'd0:    c = "y";
      5'd1:    c = "b";
      5'd2:    c = "n";
      5'd3:    c = "d";
      5'd4:    c = "r";
      5'd5:    c = "f";
      5'd6:    c = "g";
      5'd7:    c = "8";
      5'd8:    c = "e";
      5'd9:    c = "j";
      5'd10:   c = "k";
      5'd11:   c = "m";
      5'd12:   c = "c";
      5'd13:   c = "p";
      5'd14:   c = "q";
      5'd15:   c = "x";
      5'd16:   c = "o";
      5'd17:   c = "t";
      5'd18:   c = "1";
      5'd19:   c = "u";
      5'd20:   c = "w";
      5'd21:   c = "i";
      5'd22:   c = "s";
      5'd23:   c = "z";
      5'd24:   c = "a";
      5'd25:   c = "3";
      5'd26:   c = "4";
      5'd27:   c = "5";
      5'd28:   c = "h";
      5'd29:   c = "7";
      5'd30:   c = "6";
      default: c = "9";
    endcase
    return c;
  endfunction

endpackage

FILE: design/b32e_front.sv
// Front end: accepts bytes, joins leftover bits and splits them into a job of symbols.
module b32e_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [7:0]     in_data,
  input  logic           in_last,
  input  logic [3:0]     in_count,
  output logic           in_ready,
  input  logic           q_full,
  output logic           q_push,
  output b32e_pkg::job_t q_job
);

  logic [3:0]  lb_r, lb_nxt;
  logic [2:0]  lc_r, lc_nxt;
  logic [2:0]  lc;
  logic [3:0]  n;
  logic [11:0] acc;
  logic [3:0]  total;
  logic [1:0]  k;
  logic [3:0]  r;
  logic        pad_en;
  logic        fire;

  assign in_ready = !q_full;
  assign fire     = in_valid && !q_full;
  assign q_push   = fire;

  always_comb begin
    lc = (lc_r > 3'd4) ? 3'd4 : lc_r;
    n  = 4'd8;
    if (in_last && (in_count != 4'd0) && (in_count <= 4'd8)) begin
      n = in_count;
    end
    acc   = ({8'd0, lb_r} << n) | {4'd0, (in_data >> (4'd8 - n))};
    total = {1'b0, lc} + n;
    if (total >= 4'd10) begin
      k = 2'd2;
      r = total - 4'd10;
    end else if (total >= 4'd5) begin
      k = 2'd1;
      r = total - 4'd5;
    end else begin
      k = 2'd0;
      r = total;
    end
    pad_en = in_last && (r != 4'd0);

    q_job      = '0;
    q_job.eom  = in_last;
    q_job.cnt  = k + {1'b0, pad_en};
    if (k != 2'd0) begin
      q_job.syms[0] = b32e_pkg::sym_t'(acc >> (total - 4'd5));
    end
    if (k == 2'd2) begin
      q_job.syms[1] = b32e_pkg::sym_t'(acc >> (total - 4'd10));
    end
    if (pad_en) begin
      q_job.syms[k] = b32e_pkg::sym_t'(acc << (4'd5 - r));
    end

    if (in_last) begin
      lb_nxt = 4'd0;
      lc_nxt = 3'd0;
    end else begin
      lb_nxt = 4'(acc & ~(12'hfff << r));
      lc_nxt = r[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lb_r <= 4'd0;
      lc_r <= 3'd0;
    end else if (fire) begin
      lb_r <= lb_nxt;
      lc_r <= lc_nxt;
    end
  end

endmodule

FILE: design/b32e_queue.sv
// Short job queue between the front and back ends.
module b32e_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b32e_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output b32e_pkg::job_t pop_job
);

  localparam int unsigned PtrW = $clog2(b32e_pkg::QueueDepth);

  b32e_pkg::job_t          mem_r [b32e_pkg::QueueDepth];
  logic [PtrW-1:0]         wr_r, wr_nxt;
  logic [PtrW-1:0]         rd_r, rd_nxt;
  logic [PtrW:0]           cnt_r, cnt_nxt;
  logic                    do_push, do_pop;

  assign full    = (cnt_r == (PtrW+1)'(b32e_pkg::QueueDepth));
  assign empty   = (cnt_r == '0);
  assign pop_job = mem_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PtrW'(b32e_pkg::QueueDepth - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PtrW'(b32e_pkg::QueueDepth - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_job;
    end
  end

endmodule

FILE: design/b32e_back.sv
// Back end: sends the symbols of each job as characters, one beat per cycle while the receiver is ready.
module b32e_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  b32e_pkg::job_t q_job,
  output logic           q_pop,
  output logic           out_valid,
  output logic [7:0]     out_data,
  output logic           out_last,
  input  logic           out_ready
);

  b32e_pkg::job_t job_r;
  logic           job_v_r, job_v_nxt;
  logic [1:0]     idx_r, idx_nxt;
  logic           ov_r, ov_nxt;
  logic [7:0]     och_r;
  logic           olast_r;
  logic           adv;
  logic           load;
  logic           job_done;

  assign out_valid = ov_r;
  assign out_data  = och_r;
  assign out_last  = olast_r;

  always_comb begin
    adv      = !ov_r || out_ready;
    load     = adv && job_v_r && (job_r.cnt != 2'd0);
    job_done = job_v_r && ((job_r.cnt == 2'd0) || (adv && (idx_r == job_r.cnt - 2'd1)));
    q_pop    = !q_empty && (!job_v_r || job_done);

    ov_nxt = ov_r;
    if (adv) begin
      ov_nxt = load;
    end
    idx_nxt   = idx_r;
    job_v_nxt = job_v_r;
    if (job_done) begin
      job_v_nxt = 1'b0;
      idx_nxt   = 2'd0;
    end else if (load) begin
      idx_nxt = idx_r + 2'd1;
    end
    if (q_pop) begin
      job_v_nxt = 1'b1;
      idx_nxt   = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r <= 1'b0;
      idx_r   <= 2'd0;
      ov_r    <= 1'b0;
    end else begin
      job_v_r <= job_v_nxt;
      idx_r   <= idx_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
    end
    if (load) begin
      och_r   <= b32e_pkg::sym_to_char(job_r.syms[idx_r]);
      olast_r <= job_r.eom && (idx_r == job_r.cnt - 2'd1);
    end
  end

endmodule

FILE: design/base32_byte_encoder_unit.sv
// Top level of the z-base-32 byte stream encoder.
//
// Input channel in_*: one byte of the message per beat, most significant bit
// first. in_tlast marks the last byte; in_tuser gives the number of valid top
// bits of that byte (1 to 8; 0 or above 8 counts as 8, ignored when not last).
// Output channel out_*: one z-base-32 ASCII character per beat; out_tlast
// marks the last character of the encoded message.
// Each byte yields one to three characters. The front end splits each accepted
// byte combinationally and stores its symbols as a job in a two-entry queue;
// the back end sends one character per cycle from a registered output while
// the receiver is ready, so throughput is set by the output port: about 1.6
// characters per byte on long messages. The symbols of an accepted byte pass
// through the queue, the job register and the output register, in that order.
// While the receiver stalls, the output register holds its beat and the
// queue fills; in_tready drops only when both queue entries are taken.
// Reset (rst_n low, synchronous) clears the leftover bits, empties the queue
// and drops out_tvalid.
module base32_byte_encoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // final_byte
  input  logic [3:0] in_tuser,   // [3:0] final_bit_count
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] character
  output logic       out_tlast   // end_of_message
);

  logic           q_push, q_full, q_pop, q_empty;
  b32e_pkg::job_t push_job, pop_job;

  b32e_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_data  (in_tdata),
    .in_last  (in_tlast),
    .in_count (in_tuser),
    .in_ready (in_tready),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  b32e_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_job  (pop_job)
  );

  b32e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_job     (pop_job),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_data  (out_tdata),
    .out_last  (out_tlast),
    .out_ready (out_tready)
  );

endmodule
